FILE: rtl/core/girt_pkg.sv
// ----------------------------------------------------------------------------
// girt_pkg
// Shared constants, command and status codes, and types for the reservation
// table.
// ----------------------------------------------------------------------------
package girt_pkg;

    localparam int RESOURCES_DEF = 8;
    localparam int SLOTS_DEF     = 32;
    localparam int TIME_BITS_DEF = 32;

    // Command codes carried in tuser. The last code is ignored by the block.
    localparam logic [1:0] CMD_QUERY   = 2'd0;
    localparam logic [1:0] CMD_RESERVE = 2'd1;
    localparam logic [1:0] CMD_CLEAR   = 2'd2;
    localparam logic [1:0] CMD_IGNORE  = 2'd3;

    // Status codes of a result.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    // Control part of the scan token that walks down the cell row.
    typedef struct packed {
        logic valid;
        logic done;
    } t_tok_ctl;

endpackage

FILE: rtl/core/girt_cell.sv
// ----------------------------------------------------------------------------
// girt_cell
// One slot of the sorted busy lists: holds the interval of this slot for
// every resource, advances the fit scan by one slot per cycle and takes part
// in the shift that makes room for a sorted insertion.
// ----------------------------------------------------------------------------
module girt_cell
    import girt_pkg::*;
#(
    parameter int RESOURCES = RESOURCES_DEF,
    parameter int SLOTS     = SLOTS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int IDX       = 0,
    localparam int RW = (RESOURCES > 1) ? $clog2(RESOURCES) : 1,
    localparam int CW = $clog2(SLOTS + 1),
    localparam int TW = TIME_BITS,
    localparam int SW = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [RW-1:0] i_res,
    input  logic [CW-1:0] i_cnt,
    input  logic [31:0]   i_dur,
    input  t_tok_ctl      i_tok,
    input  logic [TW-1:0] i_t,
    output t_tok_ctl      o_tok,
    output logic [TW-1:0] o_t,
    input  logic          i_wr,
    input  logic [TW-1:0] i_new_s,
    input  logic [TW-1:0] i_new_e,
    input  logic [TW-1:0] i_left_s,
    input  logic [TW-1:0] i_left_e,
    input  logic          i_left_less,
    output logic [TW-1:0] o_rd_s,
    output logic [TW-1:0] o_rd_e,
    output logic          o_less
);

    logic [TW-1:0] r_start [RESOURCES];
    logic [TW-1:0] r_end   [RESOURCES];
    t_tok_ctl      r_tok, n_tok;
    logic [TW-1:0] r_t, n_t;
    logic          in_range;
    logic          fits;
    logic [SW-1:0] sum;

    assign o_rd_s   = r_start[i_res];
    assign o_rd_e   = r_end[i_res];
    assign in_range = CW'(IDX) < i_cnt;

    // This slot holds a pair that sorts before the new one.
    assign o_less = in_range && ((o_rd_s < i_new_s) ||
                                 ((o_rd_s == i_new_s) && (o_rd_e < i_new_e)));

    // One step of the earliest-fit scan.
    always_comb begin
        sum         = SW'(i_t) + SW'(i_dur);
        fits        = sum <= SW'(o_rd_s);
        n_tok.valid = i_tok.valid;
        n_tok.done  = i_tok.done | !in_range | fits;
        n_t         = i_t;
        if (!i_tok.done && in_range && !fits && (i_t < o_rd_e)) begin
            n_t = o_rd_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
        r_t <= n_t;
    end

    // Insertion: slots after the insert point take their left neighbor, the slot at it takes the new pair.
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            if ((IDX != 0) && !i_left_less) begin
                r_start[i_res] <= i_left_s;
                r_end[i_res]   <= i_left_e;
            end else if (!o_less) begin
                r_start[i_res] <= i_new_s;
                r_end[i_res]   <= i_new_e;
            end
        end
    end

    assign o_tok = r_tok;
    assign o_t   = r_t;

endmodule

FILE: rtl/core/gap_insertion_reservation_table_top.sv
// ----------------------------------------------------------------------------
// gap_insertion_reservation_table_top
// Per-resource sorted busy lists with earliest-fit search and reservation.
// ----------------------------------------------------------------------------
// One request is handled at a time. A query or reserve presents its result
// once the scan token, walking one slot per cycle down the row of SLOTS
// cells, has left the last cell; a reserve that stores passes through an
// insert state first. A clear, an ignored command or an overflowing ready
// time presents its result in the cycle after acceptance. The next request
// is accepted in the cycle after the result has been taken.
module gap_insertion_reservation_table_top
    import girt_pkg::*;
#(
    parameter int RESOURCES = RESOURCES_DEF,
    parameter int SLOTS     = SLOTS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // [2:0] resource, [34:3] earliest_start, [66:35] duration, rest zero.
    input  logic [71:0]  i_s_tdata,
    // [1:0] command.
    input  logic [1:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [31:0] start_time, [63:32] end_time, [65:64] status, [97:66] makespan.
    output logic [103:0] o_m_tdata
);

    localparam int RW = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int TW = TIME_BITS;
    localparam int SW = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;
    localparam logic [SW-1:0] TMAX = SW'((65'd1 << TIME_BITS) - 65'd1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_INS  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]    r_state;
    logic [1:0]    r_cmd;
    logic [RW-1:0] r_res;
    logic [31:0]   r_dur;
    logic [CW-1:0] r_cnt [RESOURCES];
    logic [TW-1:0] r_lat;
    logic [TW-1:0] r_t0;
    t_tok_ctl      r_tok0;
    logic [31:0]   r_out_s, r_out_e;
    logic [1:0]    r_out_st;
    logic [TW-1:0] r_new_s, r_new_e;

    logic [2:0]    in_res_raw;
    logic [RW-1:0] in_res;
    logic [31:0]   in_ready, in_dur;
    logic          in_scan;
    logic          in_ovf;
    logic          scan_go;
    logic [CW-1:0] cur_cnt;
    logic [SW-1:0] end_sum;
    logic          end_ovf;

    t_tok_ctl      tok  [SLOTS+1];
    logic [TW-1:0] tt   [SLOTS+1];
    logic [TW-1:0] rd_s [SLOTS+1];
    logic [TW-1:0] rd_e [SLOTS+1];
    logic          less [SLOTS+1];

    assign in_res_raw = i_s_tdata[2:0];
    assign in_ready   = i_s_tdata[34:3];
    assign in_dur     = i_s_tdata[66:35];
    assign cur_cnt    = r_cnt[r_res];

    // A query or reserve with a ready time in range starts a scan.
    assign in_scan = (i_s_tuser == CMD_QUERY) || (i_s_tuser == CMD_RESERVE);
    assign in_ovf  = SW'(in_ready) > TMAX;
    assign scan_go = (r_state == S_IDLE) && i_s_tvalid && in_scan && !in_ovf;

    // Resource index wraps modulo RESOURCES.
    always_comb begin
        logic [6:0] v;
        v = {4'd0, in_res_raw};
        for (int k = 0; k < 8; k++) begin
            if (v >= 7'(RESOURCES)) begin
                v = v - 7'(RESOURCES);
            end
        end
        in_res = RW'(v);
    end

    assign end_sum = SW'(tt[SLOTS]) + SW'(r_dur);
    assign end_ovf = end_sum > TMAX;

    // Left edge of the cell row.
    assign tok[0]  = r_tok0;
    assign tt[0]   = r_t0;
    assign rd_s[0] = '0;
    assign rd_e[0] = '0;
    assign less[0] = 1'b1;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        girt_cell #(
            .RESOURCES(RESOURCES), .SLOTS(SLOTS), .TIME_BITS(TIME_BITS), .IDX(g)
        ) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_res(r_res), .i_cnt(cur_cnt), .i_dur(r_dur),
            .i_tok(tok[g]), .i_t(tt[g]), .o_tok(tok[g+1]), .o_t(tt[g+1]),
            .i_wr(r_state == S_INS), .i_new_s(r_new_s), .i_new_e(r_new_e),
            .i_left_s(rd_s[g]), .i_left_e(rd_e[g]), .i_left_less(less[g]),
            .o_rd_s(rd_s[g+1]), .o_rd_e(rd_e[g+1]), .o_less(less[g+1])
        );
    end

    // Request sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tok0  <= '0;
            r_lat   <= '0;
            for (int k = 0; k < RESOURCES; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            r_tok0 <= '{valid: scan_go, done: 1'b0};
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_cmd   <= i_s_tuser;
                        r_res   <= in_res;
                        r_dur   <= in_dur;
                        r_out_e <= '0;
                        if (i_s_tuser == CMD_CLEAR) begin
                            r_out_s  <= '0;
                            r_out_st <= ST_OK;
                            r_state  <= S_OUT;
                            r_lat    <= '0;
                            for (int k = 0; k < RESOURCES; k++) begin
                                r_cnt[k] <= '0;
                            end
                        end else if (in_scan && in_ovf) begin
                            r_out_s  <= in_ready;
                            r_out_st <= ST_OVF;
                            r_state  <= S_OUT;
                        end else if (in_scan) begin
                            r_out_s  <= '0;
                            r_out_st <= ST_OK;
                            r_t0     <= TW'(in_ready);
                            r_state  <= S_SCAN;
                        end else begin
                            r_out_s  <= '0;
                            r_out_st <= ST_OK;
                            r_state  <= S_OUT;
                        end
                    end
                end
                S_SCAN: begin
                    if (tok[SLOTS].valid) begin
                        r_out_s <= 32'(tt[SLOTS]);
                        r_new_s <= tt[SLOTS];
                        r_new_e <= TW'(end_sum);
                        if (end_ovf) begin
                            r_out_st <= ST_OVF;
                            r_state  <= S_OUT;
                        end else begin
                            r_out_e <= 32'(end_sum);
                            if ((r_cmd == CMD_RESERVE) && (cur_cnt < CW'(SLOTS))) begin
                                r_state <= S_INS;
                            end else begin
                                r_state <= S_OUT;
                                if (r_cmd == CMD_RESERVE) begin
                                    r_out_st <= ST_FULL;
                                end
                            end
                        end
                    end
                end
                S_INS: begin
                    r_cnt[r_res] <= cur_cnt + CW'(1);
                    if (r_new_e > r_lat) begin
                        r_lat <= r_new_e;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_m_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready = r_state == S_IDLE;
    assign o_m_tvalid = r_state == S_OUT;
    assign o_m_tdata  = {6'd0, 32'(r_lat), r_out_st, r_out_e, r_out_s};

endmodule

FILE: rtl/core/girt_checker.sv
// ----------------------------------------------------------------------------
// girt_checker
// Port-level checks of the reservation table, bound to the top level.
// ----------------------------------------------------------------------------
module girt_checker
    import girt_pkg::*;
(
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [103:0] o_m_tdata
);

    // A pending result holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // No new request while a result is pending.
    a_one_at_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready)
        else $error("request accepted with a result pending");

    // An accepted request closes the input until its result is out.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input open right after a request");

    // An overflow reports a zero end time, and no status code beyond overflow.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[65:64] <= ST_OVF) &&
            ((o_m_tdata[65:64] != ST_OVF) || (o_m_tdata[63:32] == 32'd0)))
        else $error("bad status or end time");

endmodule

bind gap_insertion_reservation_table_top girt_checker u_girt_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
    .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
    .o_m_tdata(o_m_tdata)
);

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the reservation table against a cycle-free predictor of its busy
// lists: directed corner requests, then random reserve/query/clear/ignore traffic
// with random idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
    import girt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NRES  = 8;
    localparam int NSLOT = 32;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  res;
        logic [31:0] ready;
        logic [31:0] dur;
    } t_request;

    typedef struct packed {
        logic [31:0] start_time;
        logic [31:0] end_time;
        logic [1:0]  status;
        logic [31:0] makespan;
    } t_booking;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [71:0]  i_s_tdata = '0;
    logic [1:0]   i_s_tuser = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [103:0] o_m_tdata;

    gap_insertion_reservation_table_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: busy lists per resource and the makespan.
    logic [31:0] busy_start [NRES][NSLOT];
    logic [31:0] busy_end   [NRES][NSLOT];
    int          busy_count [NRES];
    logic [31:0] span_max;

    t_request pending_requests[$];
    t_booking expected_bookings[$];
    int  mismatch_count = 0;
    int  bookings_seen = 0;
    int  reserves_stored = 0;
    int  full_seen = 0;
    int  ovf_seen = 0;
    bit  stim_done = 1'b0;
    bit  calm_phase = 1'b0;
    int  send_idle = 0;
    int  recv_idle = 0;
    bit  hold_active = 1'b0;

    // Registered view of the input handshake for the driver.
    logic accepted_q = 1'b0;

    // Compute the result of one request and update the busy lists.
    function automatic t_booking book_request(t_request rq);
        t_booking    b;
        logic [63:0] t;
        logic [63:0] e;
        int          r;
        int          pos;
        b = '0;
        r = rq.res;
        if (rq.cmd == CMD_CLEAR) begin
            foreach (busy_count[k]) busy_count[k] = 0;
            span_max = '0;
        end else if (rq.cmd == CMD_QUERY || rq.cmd == CMD_RESERVE) begin
            // Walk the sorted list, pushing the candidate past each blocker.
            t = {32'd0, rq.ready};
            for (int i = 0; i < busy_count[r]; i++) begin
                if (t + rq.dur <= {32'd0, busy_start[r][i]}) break;
                if (t < {32'd0, busy_end[r][i]}) t = {32'd0, busy_end[r][i]};
            end
            e = t + rq.dur;
            b.start_time = t[31:0];
            if (e[63:32] != 0) begin
                b.status = ST_OVF;
            end else begin
                b.end_time = e[31:0];
                if (rq.cmd == CMD_RESERVE) begin
                    if (busy_count[r] >= NSLOT) begin
                        b.status = ST_FULL;
                    end else begin
                        pos = 0;
                        while (pos < busy_count[r] &&
                               (busy_start[r][pos] < t[31:0] ||
                                (busy_start[r][pos] == t[31:0] &&
                                 busy_end[r][pos] < e[31:0])))
                            pos++;
                        for (int i = busy_count[r]; i > pos; i--) begin
                            busy_start[r][i] = busy_start[r][i-1];
                            busy_end[r][i]   = busy_end[r][i-1];
                        end
                        busy_start[r][pos] = t[31:0];
                        busy_end[r][pos]   = e[31:0];
                        busy_count[r]++;
                        if (e[31:0] > span_max) span_max = e[31:0];
                    end
                end
            end
        end
        b.makespan = span_max;
        return b;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH booking %0d %s: got %0h expected %0h",
                 bookings_seen, what, got, want);
        mismatch_count++;
    endtask

    // Append one request to the driver's queue.
    task automatic queue_request(t_request rq);
        pending_requests = {pending_requests, rq};
    endtask

    // Driver: presents queued requests at the falling edge.
    always @(negedge i_clk) begin
        t_request rq;
        if (i_rst_n) begin
            if (!i_s_tvalid || accepted_q) begin
                if (send_idle > 0) begin
                    send_idle <= send_idle - 1;
                    i_s_tvalid <= 1'b0;
                end else if (pending_requests.size() != 0) begin
                    rq = pending_requests.pop_front();
                    i_s_tdata  <= {5'd0, rq.dur, rq.ready, rq.res};
                    i_s_tuser  <= rq.cmd;
                    i_s_tvalid <= 1'b1;
                    if (!calm_phase && $urandom_range(0, 9) == 0)
                        send_idle <= $urandom_range(1, 18);
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
            // Receiver side: long hold-off, random bursts, or always ready.
            if (hold_active) begin
                i_m_tready <= 1'b0;
            end else if (recv_idle > 0) begin
                recv_idle <= recv_idle - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
                if (!calm_phase && $urandom_range(0, 9) == 0)
                    recv_idle <= $urandom_range(1, 18);
            end
        end
    end

    // Long output hold-off, timed here while the sender keeps offering.
    initial begin
        wait (bookings_seen >= 300);
        @(negedge i_clk);
        hold_active = 1'b1;
        repeat (400) @(negedge i_clk);
        hold_active = 1'b0;
    end

    // Monitor: predicts on each accepted request, checks each taken result.
    always @(posedge i_clk) begin
        t_request rq;
        t_booking got;
        t_booking want;
        accepted_q <= i_rst_n && i_s_tvalid && o_s_tready;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            rq.cmd = i_s_tuser;
            rq.res = i_s_tdata[2:0];
            rq.ready = i_s_tdata[34:3];
            rq.dur = i_s_tdata[66:35];
            expected_bookings = {expected_bookings, book_request(rq)};
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.start_time = o_m_tdata[31:0];
            got.end_time   = o_m_tdata[63:32];
            got.status     = o_m_tdata[65:64];
            got.makespan   = o_m_tdata[97:66];
            if (expected_bookings.size() == 0) begin
                $display("MISMATCH result %0d arrived with nothing expected",
                         bookings_seen);
                mismatch_count++;
            end else begin
                want = expected_bookings.pop_front();
                if (got.start_time != want.start_time)
                    report_mismatch("start_time", got.start_time, want.start_time);
                if (got.end_time != want.end_time)
                    report_mismatch("end_time", got.end_time, want.end_time);
                if (got.status != want.status)
                    report_mismatch("status", {30'd0, got.status}, {30'd0, want.status});
                if (got.makespan != want.makespan)
                    report_mismatch("makespan", got.makespan, want.makespan);
                if (want.status == ST_FULL) full_seen++;
                if (want.status == ST_OVF) ovf_seen++;
            end
            bookings_seen++;
        end
    end

    function automatic t_request make_request(logic [1:0] c, logic [2:0] r,
                                              logic [31:0] t, logic [31:0] d);
        t_request rq;
        rq.cmd = c; rq.res = r; rq.ready = t; rq.dur = d;
        return rq;
    endfunction

    // Random duration: mostly short, sometimes wide, so every bit toggles.
    function automatic logic [31:0] pick_dur();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return 32'd0;
            default: return $urandom_range(1, 200);
        endcase
    endfunction

    function automatic logic [31:0] pick_ready();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return 32'hFFFF_FF00 + $urandom_range(0, 255);
            default: return $urandom_range(0, 3000);
        endcase
    endfunction

    // Stimulus.
    initial begin
        foreach (busy_count[k]) busy_count[k] = 0;
        span_max = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corners.
        queue_request(make_request(CMD_QUERY, 3'd0, 32'd0, 32'd0));
        queue_request(make_request(CMD_RESERVE, 3'd0, 32'd100, 32'd50));
        queue_request(make_request(CMD_RESERVE, 3'd0, 32'd0, 32'd100));
        queue_request(make_request(CMD_RESERVE, 3'd0, 32'd0, 32'd10));
        queue_request(make_request(CMD_RESERVE, 3'd0, 32'd150, 32'd0));
        queue_request(make_request(CMD_RESERVE, 3'd0, 32'd150, 32'd0));
        queue_request(make_request(CMD_QUERY, 3'd0, 32'd120, 32'd5));
        queue_request(make_request(CMD_RESERVE, 3'd7, 32'hFFFF_FFFF, 32'd0));
        queue_request(make_request(CMD_RESERVE, 3'd7, 32'hFFFF_FFFF, 32'd1));
        queue_request(make_request(CMD_QUERY, 3'd7, 32'd0, 32'hFFFF_FFFF));
        queue_request(make_request(CMD_QUERY, 3'd7, 32'd1, 32'hFFFF_FFFF));
        queue_request(make_request(CMD_IGNORE, 3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        queue_request(make_request(CMD_CLEAR, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        queue_request(make_request(CMD_QUERY, 3'd0, 32'd120, 32'd5));
        // Fill one resource to capacity and two past it.
        for (int i = 0; i < NSLOT + 2; i++)
            queue_request(make_request(CMD_RESERVE, 3'd3, 32'd0, 32'd7));

        // Random traffic, mostly reserves spread over all eight resources.
        for (int i = 0; i < 1100; i++) begin
            logic [1:0] c;
            case ($urandom_range(0, 39))
                0: c = CMD_CLEAR;
                1: c = CMD_IGNORE;
                2, 3, 4, 5, 6, 7, 8, 9, 10, 11: c = CMD_QUERY;
                default: c = CMD_RESERVE;
            endcase
            queue_request(make_request(c, 3'($urandom_range(0, 7)),
                                       pick_ready(), pick_dur()));
            // The last stretch of the run goes without idling.
            if (i == 900) begin
                wait (pending_requests.size() < 10);
                calm_phase = 1'b1;
            end
        end

        wait (pending_requests.size() == 0 && !i_s_tvalid);
        wait (expected_bookings.size() == 0);
        repeat (2 * NSLOT + 10) @(posedge i_clk);
        $display("Covered %0d results: %0d full-table rejects, %0d time overflows,",
                 bookings_seen, full_seen, ovf_seen);
        $display("with random idling on both sides and one long output stall.");
        if (mismatch_count == 0) begin
            $display("gap_insertion_reservation_table_top verification clean");
        end else begin
            $display("gap_insertion_reservation_table_top verification failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #5ms;
        $display("gap_insertion_reservation_table_top verification failed");
        $finish;
    end

endmodule

FILE: gap_insertion_reservation_table_top.f
rtl/core/girt_pkg.sv
rtl/core/girt_cell.sv
rtl/core/gap_insertion_reservation_table_top.sv
rtl/core/girt_checker.sv
sim/testbench.sv
